@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Operation codes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned LIST_DEPTH_DEF  = 128;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_READ   = 3'd4
  } ple_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } ple_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_READ_RD,
    S_READ_WAIT,
    S_DONE
  } ple_state_t;

  // result handoff from sequencer to output register
  typedef struct packed {
    logic        valid;
    ple_status_t status;
  } ple_res_ctrl_t;

endpackage

@@ rtl/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ple_core.sv @@
// ----------------------------------------------------------------------------
// ple_core: operation sequencer and shared index compare unit
// Steps through the list memory one entry at a time for shift and search.
// ----------------------------------------------------------------------------
module ple_core import ple_pkg::*; #(
  parameter int unsigned LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned CNT_W       = $clog2(LIST_DEPTH + 1),
  parameter int unsigned AW          = $clog2(LIST_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_mode,
  input  logic [CNT_W-1:0]       in_position,
  input  logic [VALUE_WIDTH-1:0] in_item_value,
  // result handoff
  output ple_res_ctrl_t          res,
  input  logic                   res_ready,
  output logic [CNT_W-1:0]       res_found,
  output logic [VALUE_WIDTH-1:0] res_rdval,
  output logic [CNT_W-1:0]       res_count,
  // list memory
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [VALUE_WIDTH-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [AW-1:0]          ram_raddr,
  input  logic [VALUE_WIDTH-1:0] ram_rdata
);

  ple_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  ple_status_t            status_r, status_nxt;
  logic [CNT_W-1:0]       found_r, found_nxt;
  logic [VALUE_WIDTH-1:0] rdval_r, rdval_nxt;

  logic                   accept;
  logic                   full;
  logic                   ins_pos_ok;
  logic                   acc_pos_ok;
  logic [CNT_W:0]         idx_inc;
  logic [CNT_W-1:0]       idx_dec;
  logic [CNT_W-1:0]       pos_dec;
  logic [CNT_W:0]         cmp_a;
  logic [CNT_W:0]         cmp_b;
  logic                   loop_go;
  logic                   hit;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // request checks on the incoming item
  assign full       = (count_r == CNT_W'(LIST_DEPTH));
  assign ins_pos_ok = (in_position != '0) &&
                      ({1'b0, in_position} <= ({1'b0, count_r} + 1'b1));
  assign acc_pos_ok = (in_position != '0) && (in_position <= count_r);

  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign pos_dec = pos_r - 1'b1;

  // shared loop compare: a < b, operands picked by the running operation
  always_comb begin
    cmp_a = {1'b0, idx_r};
    cmp_b = {1'b0, count_r};
    case (state_r)
      S_INS_RD: begin
        cmp_a = {1'b0, pos_r};
        cmp_b = idx_inc;
      end
      S_DEL_RD: begin
        cmp_a = idx_inc;
        cmp_b = {1'b0, count_r};
      end
      default: begin
        cmp_a = {1'b0, idx_r};
        cmp_b = {1'b0, count_r};
      end
    endcase
  end

  assign loop_go = (cmp_a < cmp_b);
  assign hit     = (ram_rdata == val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (ple_mode_t'(in_mode))
            MODE_INSERT: state_nxt = (!full && ins_pos_ok) ? S_INS_RD : S_DONE;
            MODE_DELETE: state_nxt = acc_pos_ok ? S_DEL_RD : S_DONE;
            MODE_SEARCH: state_nxt = S_SRCH_RD;
            MODE_READ:   state_nxt = acc_pos_ok ? S_READ_RD : S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD:    state_nxt = loop_go ? S_INS_WR : S_DONE;
      S_INS_WR:    state_nxt = S_INS_RD;
      S_DEL_RD:    state_nxt = loop_go ? S_DEL_WR : S_DONE;
      S_DEL_WR:    state_nxt = S_DEL_RD;
      S_SRCH_RD:   state_nxt = loop_go ? S_SRCH_CMP : S_DONE;
      S_SRCH_CMP:  state_nxt = hit ? S_DONE : S_SRCH_RD;
      S_READ_RD:   state_nxt = S_READ_WAIT;
      S_READ_WAIT: state_nxt = S_DONE;
      S_DONE:      state_nxt = res_ready ? S_IDLE : S_DONE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    rdval_nxt  = rdval_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt    = in_position;
          val_nxt    = in_item_value;
          status_nxt = ST_OK;
          found_nxt  = '0;
          rdval_nxt  = '0;
          case (ple_mode_t'(in_mode))
            MODE_CLEAR: count_nxt = '0;
            MODE_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (!ins_pos_ok) begin
                status_nxt = ST_BADPOS;
              end
              idx_nxt = count_r;
            end
            MODE_DELETE: begin
              if (!acc_pos_ok) begin
                status_nxt = ST_BADPOS;
              end
              idx_nxt = in_position - 1'b1;
            end
            MODE_SEARCH: idx_nxt = '0;
            MODE_READ: begin
              if (!acc_pos_ok) begin
                status_nxt = ST_BADPOS;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        // move entry idx-1 up to idx; when done, drop the new value in
        if (loop_go) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_dec[AW-1:0];
          ram_wdata = val_r;
          count_nxt = count_r + 1'b1;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
      end
      S_DEL_RD: begin
        // move entry idx+1 down to idx
        if (loop_go) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc[CNT_W-1:0];
      end
      S_SRCH_RD: begin
        if (loop_go) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      S_SRCH_CMP: begin
        if (hit) begin
          found_nxt = idx_inc[CNT_W-1:0];
        end else begin
          idx_nxt = idx_inc[CNT_W-1:0];
        end
      end
      S_READ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_dec[AW-1:0];
      end
      S_READ_WAIT: rdval_nxt = ram_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    rdval_r  <= rdval_nxt;
  end

  assign res.valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res_found  = found_r;
  assign res_rdval  = rdval_r;
  assign res_count  = count_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !ram_we)
    else $error("memory write outside an operation");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the list");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == ST_NOTFOUND) |-> (found_r == '0))
    else $error("failed search reports a position");
`endif

endmodule

@@ rtl/positional_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list with insert, delete, search, read
// Sequencer over a single list memory plus an output result register.
// ----------------------------------------------------------------------------
// Steps (c = count, p = position): insert moves entries p..c up one place, delete
//   moves entries p+1..c down one place, search compares entries from the first until
//   a hit or entry c, read does one memory read; each result then goes through the
//   output register. One transaction at a time; each shift or compare step is a read
//   state then a write or compare state, as each entry passes the one read port.
// Reset (rst_n low, synchronous): list emptied, no result pending.
// ----------------------------------------------------------------------------
module positional_list_engine_top import ple_pkg::*; #(
  parameter int unsigned LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned CNT_W       = $clog2(LIST_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_mode,
  input  logic [CNT_W-1:0]       in_position,
  input  logic [VALUE_WIDTH-1:0] in_item_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [CNT_W-1:0]       out_found_position,
  output logic [VALUE_WIDTH-1:0] out_read_value,
  output logic [CNT_W-1:0]       out_count_now
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);

  ple_res_ctrl_t          res;
  logic                   res_ready;
  logic [CNT_W-1:0]       res_found;
  logic [VALUE_WIDTH-1:0] res_rdval;
  logic [CNT_W-1:0]       res_count;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // output result register; frees the sequencer while a result waits
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r;
  logic [CNT_W-1:0]       found_r;
  logic [VALUE_WIDTH-1:0] rdval_r;
  logic [CNT_W-1:0]       count_r;
  logic                   load;

  // list storage: one entry per position, read data registered
  ple_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // operation sequencer
  ple_core #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W),
    .AW          (AW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .res           (res),
    .res_ready     (res_ready),
    .res_found     (res_found),
    .res_rdval     (res_rdval),
    .res_count     (res_count),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // take a new result when the register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;
  assign load      = res.valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res.status;
      found_r  <= res_found;
      rdval_r  <= res_rdval;
      count_r  <= res_count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_read_value     = rdval_r;
  assign out_count_now      = count_r;

endmodule
